// ----- rtl/core/rgbhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    // Per-pixel flags carried alongside the division chain
    typedef struct packed {
        logic gray;      // delta is zero: hue and saturation forced to zero
        logic sat_full;  // delta equals value: saturation clamps to all ones
    } flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/rgbhsv_front.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_front
// Head cell: picks the dominant channel, forms delta, the hue numerator and
// divisor, and the saturation remainder for the division chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [CHANNEL_BITS-1:0]        red,
    input  wire  [CHANNEL_BITS-1:0]        green,
    input  wire  [CHANNEL_BITS-1:0]        blue,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [CHANNEL_BITS+2:0]        h_rem,
    output logic [CHANNEL_BITS+2:0]        h_div,
    output logic [CHANNEL_BITS-1:0]        s_rem,
    output logic [CHANNEL_BITS-1:0]        s_div,
    output logic [FRACTION_BITS-1:0]       h_quo,
    output logic [FRACTION_BITS-1:0]       s_quo,
    output rgbhsv_pkg::flags_t             flags
);

    localparam int C = CHANNEL_BITS;

    logic                 valid_reg;
    logic [C+2:0]         h_rem_reg, h_rem_next;
    logic [C+2:0]         h_div_reg, h_div_next;
    logic [C-1:0]         s_rem_reg, s_rem_next;
    logic [C-1:0]         s_div_reg, s_div_next;
    rgbhsv_pkg::flags_t   flags_reg, flags_next;

    logic [C-1:0]         dom, c1, c2, lo, delta;
    logic [1:0]           off_shift;
    logic [C+3:0]         off_term, num, num_fix;
    logic [C+2:0]         six_delta;

    always_comb begin
        // strict comparisons: blue wins only when strictly largest; ties favour green over blue and red over green
        if (blue > green && blue > red) begin
            dom = blue; c1 = red;  c2 = green; off_shift = 2'd2;
        end else if (green > red) begin
            dom = green; c1 = blue; c2 = red;  off_shift = 2'd1;
        end else begin
            dom = red;  c1 = green; c2 = blue; off_shift = 2'd0;
        end
        lo        = (c1 > c2) ? c2 : c1;
        delta     = dom - lo;
        six_delta = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
        case (off_shift)
            2'd2:    off_term = {2'b00, delta, 2'b00};
            2'd1:    off_term = {3'b000, delta, 1'b0};
            default: off_term = '0;
        endcase
        // two's complement numerator, wrapped by one turn when negative
        num     = off_term + {4'b0000, c1} - {4'b0000, c2};
        num_fix = num[C+3] ? (num + {1'b0, six_delta}) : num;

        h_rem_next          = num_fix[C+2:0];
        h_div_next          = six_delta;
        s_div_next          = dom;
        s_rem_next          = (delta == dom) ? '0 : delta;
        flags_next.gray     = (delta == '0);
        flags_next.sat_full = (delta == dom) && (delta != '0);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            h_rem_reg <= h_rem_next;
            h_div_reg <= h_div_next;
            s_rem_reg <= s_rem_next;
            s_div_reg <= s_div_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign h_rem     = h_rem_reg;
    assign h_div     = h_div_reg;
    assign s_rem     = s_rem_reg;
    assign s_div     = s_div_reg;
    assign h_quo     = '0;
    assign s_quo     = '0;
    assign flags     = flags_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rgbhsv_div_cell.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_div_cell
// One restoring division step for hue and saturation at once: shift the
// remainders, compare, subtract, append one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div_cell #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [CHANNEL_BITS+2:0]        h_rem_in,
    input  wire  [CHANNEL_BITS+2:0]        h_div_in,
    input  wire  [CHANNEL_BITS-1:0]        s_rem_in,
    input  wire  [CHANNEL_BITS-1:0]        s_div_in,
    input  wire  [FRACTION_BITS-1:0]       h_quo_in,
    input  wire  [FRACTION_BITS-1:0]       s_quo_in,
    input  rgbhsv_pkg::flags_t             flags_in,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [CHANNEL_BITS+2:0]        h_rem_out,
    output logic [CHANNEL_BITS+2:0]        h_div_out,
    output logic [CHANNEL_BITS-1:0]        s_rem_out,
    output logic [CHANNEL_BITS-1:0]        s_div_out,
    output logic [FRACTION_BITS-1:0]       h_quo_out,
    output logic [FRACTION_BITS-1:0]       s_quo_out,
    output rgbhsv_pkg::flags_t             flags_out
);

    localparam int C = CHANNEL_BITS;
    localparam int F = FRACTION_BITS;

    logic                 valid_reg;
    logic [C+2:0]         h_rem_reg, h_rem_next;
    logic [C+2:0]         h_div_reg;
    logic [C-1:0]         s_rem_reg, s_rem_next;
    logic [C-1:0]         s_div_reg;
    logic [F-1:0]         h_quo_reg, h_quo_next;
    logic [F-1:0]         s_quo_reg, s_quo_next;
    rgbhsv_pkg::flags_t   flags_reg;

    logic [C+3:0]         h_sh, h_diff;
    logic [C:0]           s_sh, s_diff;
    logic                 h_ge, s_ge;

    always_comb begin
        h_sh   = {h_rem_in, 1'b0};
        h_diff = h_sh - {1'b0, h_div_in};
        h_ge   = (h_sh >= {1'b0, h_div_in});
        s_sh   = {s_rem_in, 1'b0};
        s_diff = s_sh - {1'b0, s_div_in};
        s_ge   = (s_sh >= {1'b0, s_div_in});

        h_rem_next = h_ge ? h_diff[C+2:0] : h_sh[C+2:0];
        s_rem_next = s_ge ? s_diff[C-1:0] : s_sh[C-1:0];
        h_quo_next = {h_quo_in[F-2:0], h_ge};
        s_quo_next = {s_quo_in[F-2:0], s_ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            h_rem_reg <= h_rem_next;
            h_div_reg <= h_div_in;
            s_rem_reg <= s_rem_next;
            s_div_reg <= s_div_in;
            h_quo_reg <= h_quo_next;
            s_quo_reg <= s_quo_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign h_rem_out = h_rem_reg;
    assign h_div_out = h_div_reg;
    assign s_rem_out = s_rem_reg;
    assign s_div_out = s_div_reg;
    assign h_quo_out = h_quo_reg;
    assign s_quo_out = s_quo_reg;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion: one pixel per clock, unless stalled, through
// a head cell and a row of restoring division cells.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Direction  Per request
//   --------  --------------------------------------  ---------  -----------------
//   input     s_valid s_ready s_red s_green s_blue    in         one RGB pixel
//   result    m_valid m_ready m_hue m_saturation      out        one HSV pixel
//             m_brightness
//
// Pipeline: a request accepted at the input lands in the head cell and passes
// through FRACTION_BITS + 1 registers (the head cell plus one division cell for
// each quotient bit) on its way to the result port; a new request may enter at
// every edge while the row is not stalled.
// Reset: aresetn, synchronous and active low, empties every cell.
// Stalls: each cell holds its request only while its downstream neighbour
// is full and stalled, so bubbles close up and s_ready drops only when
// every cell holds a request and m_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire  [CHANNEL_BITS-1:0]    s_red,
    input  wire  [CHANNEL_BITS-1:0]    s_green,
    input  wire  [CHANNEL_BITS-1:0]    s_blue,
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic [FRACTION_BITS-1:0]   m_hue,
    output logic [FRACTION_BITS-1:0]   m_saturation,
    output logic [CHANNEL_BITS-1:0]    m_brightness
);

    localparam int C = CHANNEL_BITS;
    localparam int F = FRACTION_BITS;

    // Link k joins cell k-1 to cell k; link 0 is the head cell's output and
    // link F is the last division cell's output.
    logic                 link_valid [0:F];
    logic                 link_ready [0:F];
    logic [C+2:0]         link_h_rem [0:F];
    logic [C+2:0]         link_h_div [0:F];
    logic [C-1:0]         link_s_rem [0:F];
    logic [C-1:0]         link_s_div [0:F];
    logic [F-1:0]         link_h_quo [0:F];
    logic [F-1:0]         link_s_quo [0:F];
    rgbhsv_pkg::flags_t   link_flags [0:F];

    // Head cell: dominant channel, delta, numerators and divisors
    rgbhsv_front #(
        .CHANNEL_BITS  (C),
        .FRACTION_BITS (F)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .h_rem     (link_h_rem[0]),
        .h_div     (link_h_div[0]),
        .s_rem     (link_s_rem[0]),
        .s_div     (link_s_div[0]),
        .h_quo     (link_h_quo[0]),
        .s_quo     (link_s_quo[0]),
        .flags     (link_flags[0])
    );

    // One quotient bit per cell, most significant first
    for (genvar k = 0; k < F; k++) begin : g_cell
        rgbhsv_div_cell #(
            .CHANNEL_BITS  (C),
            .FRACTION_BITS (F)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .h_rem_in  (link_h_rem[k]),
            .h_div_in  (link_h_div[k]),
            .s_rem_in  (link_s_rem[k]),
            .s_div_in  (link_s_div[k]),
            .h_quo_in  (link_h_quo[k]),
            .s_quo_in  (link_s_quo[k]),
            .flags_in  (link_flags[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .h_rem_out (link_h_rem[k+1]),
            .h_div_out (link_h_div[k+1]),
            .s_rem_out (link_s_rem[k+1]),
            .s_div_out (link_s_div[k+1]),
            .h_quo_out (link_h_quo[k+1]),
            .s_quo_out (link_s_quo[k+1]),
            .flags_out (link_flags[k+1])
        );
    end

    // The last cell's registers are the result register
    assign link_ready[F] = m_ready;
    assign m_valid       = link_valid[F];
    assign m_brightness  = link_s_div[F];

    always_comb begin
        // Drop the quotients for gray and black pixels; clamp a full
        // saturation, whose exact value 1.0 does not fit the fraction.
        if (link_flags[F].gray) begin
            m_hue        = '0;
            m_saturation = '0;
        end else begin
            m_hue        = link_h_quo[F];
            m_saturation = link_flags[F].sat_full ? '1 : link_s_quo[F];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Back-pressure reaches the input only when the whole row is stalled
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low while the result port is not stalled");

    // A request taken at the input always lands in the head cell
    a_head_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> link_valid[0])
        else $error("accepted request lost at the head cell");

    // Black pixels carry zero hue and zero saturation
    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_brightness == '0) |-> (m_hue == '0 && m_saturation == '0))
        else $error("black pixel with nonzero hue or saturation");

endmodule

`default_nettype wire
